/* rtl/gbts_pkg.sv */
// gbts_pkg: shared types, codes and constants for the gap buffer text store
// depends on nothing; imported by every module of the block

package gbts_pkg;

  // default store size and the refill byte
  localparam int          STORE_DEPTH_DEF = 128;
  localparam logic [7:0]  FILL_CHAR       = 8'd95;

  // operation codes carried on the input tuser
  localparam logic [1:0]  OP_INSERT = 2'd0;
  localparam logic [1:0]  OP_MOVE   = 2'd1;
  localparam logic [1:0]  OP_READ   = 2'd2;

  // result status codes
  localparam logic [1:0]  STAT_OK    = 2'd0;
  localparam logic [1:0]  STAT_FULL  = 2'd1;
  localparam logic [1:0]  STAT_RANGE = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MV_RD,
    S_MV_WR,
    S_FIN
  } seq_state_t;

  // one update request to the gap pointer unit
  typedef struct packed {
    logic insert;
    logic step_left;
    logic step_right;
  } gap_cmd_t;

  // compare results from the gap pointer unit
  typedef struct packed {
    logic full;        // gap is empty
    logic beyond;      // target past the text length
    logic at_cursor;   // target equals gap start
    logic left;        // target below gap start
    logic more_left;   // after this step, still above target
    logic more_right;  // after this step, still below target and text remains
  } gap_flags_t;

  // one result word
  typedef struct packed {
    logic [7:0] text_length;
    logic [7:0] cursor;
    logic [7:0] char_out;
    logic [1:0] status;
  } result_t;

endpackage

/* rtl/gbts_ram.sv */
// gbts_ram: single write, single read byte memory holding the text and the gap
// depends on gbts_pkg for the default store depth

module gbts_ram
  import gbts_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [7:0]    wd,
  input  logic [AW-1:0] ra,
  output logic [7:0]    rd
);

  logic [7:0] mem [STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

/* rtl/gbts_gap_unit.sv */
// gbts_gap_unit: gap start and end registers with the shared step adder and compares
// depends on gbts_pkg for gap_cmd_t and gap_flags_t

module gbts_gap_unit
  import gbts_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  localparam int CW   = $clog2(STORE_DEPTH + 1),
  localparam int CMPW = (CW > 8) ? CW : 8
) (
  input  logic            clk,
  input  logic            rst,
  input  gap_cmd_t        cmd,
  input  logic [CMPW-1:0] tgt,
  output logic [CW-1:0]   gs,
  output logic [CW-1:0]   ge,
  output logic [CW-1:0]   gs_next,
  output logic [CW-1:0]   len_next,
  output gap_flags_t      flags
);

  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

  logic [CW-1:0]   ge_next;
  logic [CW-1:0]   len;
  logic [CMPW-1:0] gs_w;
  logic [CMPW-1:0] gs_next_w;
  logic [CMPW-1:0] len_w;

  // shared step: insert moves gap start, a shift moves both ends
  always_comb begin
    gs_next = gs;
    ge_next = ge;
    if (cmd.insert) begin
      gs_next = gs + CW'(1);
    end else if (cmd.step_left) begin
      gs_next = gs - CW'(1);
      ge_next = ge - CW'(1);
    end else if (cmd.step_right) begin
      gs_next = gs + CW'(1);
      ge_next = ge + CW'(1);
    end
  end

  // text length now and after the step
  assign len      = DEPTH_C - (ge - gs);
  assign len_next = DEPTH_C - (ge_next - gs_next);

  assign gs_w      = CMPW'(gs);
  assign gs_next_w = CMPW'(gs_next);
  assign len_w     = CMPW'(len);

  // compares against the target position
  always_comb begin
    flags.full       = (gs >= ge);
    flags.beyond     = (tgt > len_w);
    flags.at_cursor  = (tgt == gs_w);
    flags.left       = (tgt < gs_w);
    flags.more_left  = (gs_next_w > tgt);
    flags.more_right = (gs_next_w < tgt) && (ge_next < DEPTH_C);
  end

  // pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gs <= '0;
      ge <= DEPTH_C;
    end else begin
      gs <= gs_next;
      ge <= ge_next;
    end
  end

endmodule

/* rtl/gbts_seq.sv */
// gbts_seq: sequencer for clearing, insert, read and the one-slot-at-a-time cursor move
// depends on gbts_pkg; drives gbts_ram and gbts_gap_unit

module gbts_seq
  import gbts_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  localparam int AW   = $clog2(STORE_DEPTH),
  localparam int CW   = $clog2(STORE_DEPTH + 1),
  localparam int CMPW = (CW > 8) ? CW : 8
) (
  input  logic            clk,
  input  logic            rst,
  // input word
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_func,
  input  logic [7:0]      in_char,
  input  logic [7:0]      in_pos,
  // result word
  output logic            res_valid,
  output result_t         res,
  input  logic            out_free,
  // memory
  output logic            ram_we,
  output logic [AW-1:0]   ram_wa,
  output logic [7:0]      ram_wd,
  output logic [AW-1:0]   ram_ra,
  input  logic [7:0]      ram_rd,
  // gap unit
  output gap_cmd_t        cmd,
  output logic [CMPW-1:0] tgt,
  input  logic [CW-1:0]   gs,
  input  logic [CW-1:0]   ge,
  input  logic [CW-1:0]   gs_next,
  input  logic [CW-1:0]   len_next,
  input  gap_flags_t      flags
);

  localparam logic [AW-1:0]   CLR_LAST = AW'(STORE_DEPTH - 1);
  localparam logic [CMPW-1:0] DEPTH_W  = CMPW'(STORE_DEPTH);

  seq_state_t      state, state_next;
  logic [AW-1:0]   clr_cnt;
  logic [1:0]      func;
  logic [7:0]      ch;
  logic [CMPW-1:0] pos;
  logic            dir_left;
  result_t         res_q;
  result_t         res_now;
  logic            finish;
  logic [AW-1:0]   src_addr;
  logic [AW-1:0]   dst_addr;
  logic [CMPW-1:0] in_pos_w;

  assign in_pos_w = CMPW'(in_pos);
  assign tgt      = pos;

  // shift addresses: left moves slot gs-1 to ge-1, right moves ge to gs
  assign src_addr = dir_left ? AW'(gs - CW'(1)) : AW'(ge);
  assign dst_addr = dir_left ? AW'(ge - CW'(1)) : AW'(gs);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == CLR_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (func == OP_MOVE && !flags.beyond && !flags.at_cursor) begin
          state_next = S_MV_RD;
        end else if (!out_free) begin
          state_next = S_FIN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MV_RD: state_next = S_MV_WR;
      S_MV_WR: begin
        if (dir_left ? flags.more_left : flags.more_right) begin
          state_next = S_MV_RD;
        end else if (!out_free) begin
          state_next = S_FIN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs per state
  always_comb begin
    in_ready         = 1'b0;
    ram_we           = 1'b0;
    ram_wa           = src_addr;
    ram_wd           = FILL_CHAR;
    ram_ra           = src_addr;
    cmd              = '0;
    finish           = 1'b0;
    res_now.status   = STAT_OK;
    res_now.char_out = 8'd0;
    res_now.cursor   = 8'(gs_next);
    res_now.text_length = 8'(len_next);
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = clr_cnt;
      end
      S_IDLE: begin
        // read is issued on the incoming position so data is ready next cycle
        in_ready = 1'b1;
        ram_ra   = AW'(in_pos_w);
      end
      S_EXEC: begin
        case (func)
          OP_INSERT: begin
            finish = 1'b1;
            if (flags.full) begin
              res_now.status = STAT_FULL;
            end else begin
              ram_we     = 1'b1;
              ram_wa     = AW'(gs);
              ram_wd     = ch;
              cmd.insert = 1'b1;
            end
          end
          OP_MOVE: begin
            if (flags.beyond) begin
              finish         = 1'b1;
              res_now.status = STAT_RANGE;
            end else if (flags.at_cursor) begin
              finish = 1'b1;
            end
          end
          OP_READ: begin
            finish = 1'b1;
            if (pos >= DEPTH_W) begin
              res_now.status = STAT_RANGE;
            end else begin
              res_now.char_out = ram_rd;
            end
          end
          default: finish = 1'b1;
        endcase
      end
      S_MV_RD: begin
        // fetch the slot leaving and refill it in the same cycle
        ram_we = 1'b1;
      end
      S_MV_WR: begin
        ram_we         = 1'b1;
        ram_wa         = dst_addr;
        // with no gap the slot moves onto itself and ends up refilled
        ram_wd         = flags.full ? FILL_CHAR : ram_rd;
        cmd.step_left  = dir_left;
        cmd.step_right = !dir_left;
        finish         = !(dir_left ? flags.more_left : flags.more_right);
      end
      default: ;
    endcase
  end

  // result handoff, held here while the output register is busy
  assign res_valid = finish || (state == S_FIN);
  assign res       = (state == S_FIN) ? res_q : res_now;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // item and pending result registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      func <= in_func;
      ch   <= in_char;
      pos  <= in_pos_w;
    end
    if (state == S_EXEC) dir_left <= flags.left;
    if (finish && !out_free) res_q <= res_now;
  end

endmodule

/* rtl/gap_buffer_text_store.sv */
// gap_buffer_text_store: top level with stream ports and the output register
// depends on gbts_pkg, gbts_ram, gbts_gap_unit and gbts_seq
//
//   channel   dir  tdata fields (low bit up)                        tuser
//   s_*       in   char_in[7:0], position[15:8]                     func[1:0]
//   m_*       out  status[1:0], char_out[9:2], cursor[17:10],       -
//                  text_length[25:18]
//
// insert, read and refused operations are accepted in the idle state and finished in the
// execute state, at whose end the result word is loaded if the output register is free.
// a cursor move shifts one character at a time across the gap:
// each shift needs a read-and-refill write and a data write on the one memory write port.
// after reset the memory is swept to '_' with s_tready low.
// a new word is taken while a result waits in the output register; the block then
// holds its own finished result until m_tready frees that register.

module gap_buffer_text_store
  import gbts_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // char_in[7:0], position[15:8]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // status[1:0], char_out[9:2], cursor[17:10], text_length[25:18]
);

  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int CW   = $clog2(STORE_DEPTH + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;

  logic            ram_we;
  logic [AW-1:0]   ram_wa;
  logic [7:0]      ram_wd;
  logic [AW-1:0]   ram_ra;
  logic [7:0]      ram_rd;
  gap_cmd_t        cmd;
  logic [CMPW-1:0] tgt;
  logic [CW-1:0]   gs;
  logic [CW-1:0]   ge;
  logic [CW-1:0]   gs_next;
  logic [CW-1:0]   len_next;
  gap_flags_t      flags;
  logic            res_valid;
  result_t         res;
  logic            out_free;

  gbts_ram #(.STORE_DEPTH(STORE_DEPTH)) u_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

  gbts_gap_unit #(.STORE_DEPTH(STORE_DEPTH)) u_gap (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .tgt      (tgt),
    .gs       (gs),
    .ge       (ge),
    .gs_next  (gs_next),
    .len_next (len_next),
    .flags    (flags)
  );

  gbts_seq #(.STORE_DEPTH(STORE_DEPTH)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tuser),
    .in_char   (s_tdata[7:0]),
    .in_pos    (s_tdata[15:8]),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .ram_we    (ram_we),
    .ram_wa    (ram_wa),
    .ram_wd    (ram_wd),
    .ram_ra    (ram_ra),
    .ram_rd    (ram_rd),
    .cmd       (cmd),
    .tgt       (tgt),
    .gs        (gs),
    .ge        (ge),
    .gs_next   (gs_next),
    .len_next  (len_next),
    .flags     (flags)
  );

  // output register is free when empty or being drained
  assign out_free = !m_tvalid || m_tready;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_valid;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      m_tdata <= {6'd0, res};
    end
  end

endmodule

/* sim/gap_buffer_text_store_tb.sv */
// gap_buffer_text_store_tb: self-checking bench for the gap buffer text store
// depends on gbts_pkg and gap_buffer_text_store; a shadow store predicts every result word
`timescale 1ns / 1ps

module gap_buffer_text_store_tb
  import gbts_pkg::*;
();

  localparam int          TEXT_DEPTH  = STORE_DEPTH_DEF;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int          HOLD_CYCLES = 240;
  localparam int          DRAIN_WAIT  = 2 * TEXT_DEPTH + 40;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;    // char_in[7:0], position[15:8]
  logic [1:0]  s_tuser;    // func[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;    // status[1:0], char_out[9:2], cursor[17:10], text_length[25:18]

  // shadow copy of the store and the gap pointers
  logic [7:0]  shadow_text [TEXT_DEPTH];
  int unsigned gap_head;
  int unsigned gap_tail;

  result_t     pending_results [$];
  int          fail_count;
  int          burst_left;
  bit          bursty;
  int          sink_mode;
  bit          hold_pending;

  gap_buffer_text_store #(
    .STORE_DEPTH(TEXT_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // characters currently held
  function automatic int unsigned held_chars();
    return TEXT_DEPTH - (gap_tail - gap_head);
  endfunction

  // apply one operation to the shadow store and build the expected result word
  function automatic result_t edit_result(logic [1:0] op, logic [7:0] ch, logic [7:0] pos);
    result_t     r;
    int unsigned target;
    r      = '0;
    target = 32'(pos);
    case (op)
      OP_INSERT: begin
        if (gap_head >= gap_tail) begin
          r.status = STAT_FULL;
        end else begin
          shadow_text[gap_head] = ch;
          gap_head++;
        end
      end
      OP_MOVE: begin
        if (target > held_chars()) begin
          r.status = STAT_RANGE;
        end else if (target < gap_head) begin
          // text left of the cursor moves to the far side of the gap
          while (gap_head > target) begin
            gap_head--;
            gap_tail--;
            shadow_text[gap_tail] = shadow_text[gap_head];
            shadow_text[gap_head] = FILL_CHAR;
          end
        end else if (target > gap_head) begin
          while (gap_head < target && gap_tail < TEXT_DEPTH) begin
            shadow_text[gap_head] = shadow_text[gap_tail];
            shadow_text[gap_tail] = FILL_CHAR;
            gap_head++;
            gap_tail++;
          end
        end
      end
      OP_READ: begin
        if (target >= TEXT_DEPTH) r.status = STAT_RANGE;
        else r.char_out = shadow_text[target];
      end
      default: ;
    endcase
    r.cursor      = gap_head[7:0];
    r.text_length = 8'(held_chars());
    return r;
  endfunction

  // offer one word, with idle gaps between bursts; returns at a falling edge
  task automatic send_word(logic [1:0] op, logic [7:0] ch, logic [7:0] pos);
    result_t want_word;
    if (bursty && burst_left == 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 16'($urandom);
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(9, 40)) @(negedge clk);
      else repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {pos, ch};
    do @(posedge clk); while (!s_tready);
    want_word       = edit_result(op, ch, pos);
    pending_results = {pending_results, want_word};
    @(negedge clk);
  endtask

  // stop offering until every expected word is back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    result_t seen;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen = m_tdata[25:0];
      if (pending_results.size() == 0) begin
        $error("unexpected result word %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, seen.status);
        check_field("char_out", want.char_out, seen.char_out);
        check_field("cursor", want.cursor, seen.cursor);
        check_field("text_length", want.text_length, seen.text_length);
      end
    end
  end

  // result receiver: stall pattern per mode, plus one long hold-off on request
  initial begin : result_sink
    int cyc;
    cyc      = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_pending) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_pending = 1'b0;
      end else begin
        case (sink_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 3) != 0);
          2:       m_tready <= ((cyc % 7) < 4);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // random edit traffic: inserts, mostly legal moves and reads, some out of range and unused ops
  task automatic random_edits(int count, int insert_pct);
    logic [1:0] op;
    logic [7:0] ch;
    logic [7:0] pos;
    int         k;
    for (int i = 0; i < count; i++) begin
      k  = $urandom_range(0, 99);
      ch = 8'($urandom_range(0, 255));
      if (k < insert_pct) begin
        op  = OP_INSERT;
        pos = 8'($urandom_range(0, 255));
      end else if (k < insert_pct + 45) begin
        op = OP_MOVE;
        if ($urandom_range(0, 9) == 0) pos = 8'($urandom_range(0, 255));
        else pos = 8'($urandom_range(0, held_chars() + 1));
      end else if (k < 97) begin
        op = OP_READ;
        if ($urandom_range(0, 9) == 0) pos = 8'($urandom_range(0, 255));
        else pos = 8'($urandom_range(0, TEXT_DEPTH - 1));
      end else begin
        op  = OP_UNUSED;
        pos = 8'($urandom_range(0, 255));
      end
      if (i % 80 == 79) begin
        sink_mode = $urandom_range(0, 3);
        bursty    = ($urandom_range(0, 3) != 0);
      end
      send_word(op, ch, pos);
    end
  endtask

  // extremes of every field and each corner of the empty and short store
  task automatic test_directed();
    sink_mode = 1;
    bursty    = 1'b1;
    send_word(OP_READ, 8'h00, 8'd0);
    send_word(OP_READ, 8'hff, 8'd127);
    send_word(OP_READ, 8'h00, 8'd128);
    send_word(OP_READ, 8'hff, 8'd255);
    send_word(OP_UNUSED, 8'hff, 8'hff);
    send_word(OP_MOVE, 8'h00, 8'd0);
    send_word(OP_MOVE, 8'h00, 8'd1);
    send_word(OP_INSERT, 8'h00, 8'hff);
    send_word(OP_INSERT, 8'hff, 8'h00);
    send_word(OP_INSERT, 8'h41, 8'h00);
    send_word(OP_INSERT, 8'h7a, 8'h00);
    send_word(OP_MOVE, 8'h00, 8'd0);
    for (int s = TEXT_DEPTH - 4; s < TEXT_DEPTH; s++) send_word(OP_READ, 8'h00, 8'(s));
    send_word(OP_MOVE, 8'h00, 8'd4);
    send_word(OP_MOVE, 8'h00, 8'd4);
    send_word(OP_MOVE, 8'h00, 8'd2);
    send_word(OP_INSERT, 8'h80, 8'h00);
    send_word(OP_MOVE, 8'h00, 8'd5);
    send_word(OP_MOVE, 8'h00, 8'd6);
    send_word(OP_READ, 8'h00, 8'd2);
    send_word(OP_MOVE, 8'hff, 8'd255);
    send_word(OP_READ, 8'h00, 8'd127);
    wait_for_results();
  endtask

  // editing while the store is far from full
  task automatic test_light_editing();
    random_edits(380, 12);
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_backpressure();
    bursty       = 1'b0;
    sink_mode    = 0;
    hold_pending = 1'b1;
    random_edits(30, 20);
    wait_for_results();
  endtask

  // fill the store, then hit it with refused inserts and whole-text moves
  task automatic test_fill_store();
    bursty    = 1'b1;
    sink_mode = 1;
    while (held_chars() < TEXT_DEPTH) begin
      send_word(OP_INSERT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    send_word(OP_INSERT, 8'h00, 8'h00);
    send_word(OP_INSERT, 8'hff, 8'hff);
    send_word(OP_MOVE, 8'h00, 8'd0);
    send_word(OP_MOVE, 8'h00, 8'd128);
    send_word(OP_MOVE, 8'h00, 8'd129);
    send_word(OP_MOVE, 8'h00, 8'd64);
    send_word(OP_INSERT, 8'h55, 8'h00);
    send_word(OP_READ, 8'h00, 8'd64);
    send_word(OP_READ, 8'h00, 8'd127);
    wait_for_results();
  endtask

  // editing on a full store
  task automatic test_full_editing();
    random_edits(140, 20);
  endtask

  // run limit
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = OP_INSERT;
    fail_count   = 0;
    burst_left   = 0;
    bursty       = 1'b1;
    sink_mode    = 0;
    hold_pending = 1'b0;
    for (int s = 0; s < TEXT_DEPTH; s++) shadow_text[s] = FILL_CHAR;
    gap_head = 0;
    gap_tail = TEXT_DEPTH;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_light_editing();
    test_backpressure();
    test_fill_store();
    test_full_editing();

    wait_for_results();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/gbts_pkg.sv
rtl/gbts_ram.sv
rtl/gbts_gap_unit.sv
rtl/gbts_seq.sv
rtl/gap_buffer_text_store.sv
sim/gap_buffer_text_store_tb.sv
